FILE: sv/hhd_pkg.sv
// ----------------------------------------------------------------------------
// hhd_pkg
// Shared types and constants for the HCI H4 packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hhd_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 1024;

  // Byte counter and packet total width: largest total is 65535 + 5.
  localparam int CNT_W = 17;

  localparam logic [7:0] TYPE_ACL = 8'h02;
  localparam logic [7:0] TYPE_EVT = 8'h04;

  localparam logic [CNT_W-1:0] ACL_HDR_BYTES = CNT_W'(5);
  localparam logic [CNT_W-1:0] EVT_HDR_BYTES = CNT_W'(3);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_event;
    logic       first_byte;
    logic       last_byte;
    logic       truncated;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/hhd_byte_if.sv
// ----------------------------------------------------------------------------
// hhd_byte_if
// Valid/ready channel carrying one received UART byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/hhd_pkt_if.sv
// ----------------------------------------------------------------------------
// hhd_pkt_if
// Valid/ready channel carrying one framed packet byte with its marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhd_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_event;
  logic       first_byte;
  logic       last_byte;
  logic       truncated;

  modport source (output valid, output data_byte, output is_event, output first_byte,
                  output last_byte, output truncated, input ready);
  modport sink   (input valid, input data_byte, input is_event, input first_byte,
                  input last_byte, input truncated, output ready);
endinterface

`default_nettype wire

FILE: sv/hhd_framer.sv
// ----------------------------------------------------------------------------
// hhd_framer
// Framing state: type hunting, header length capture, payload counting.
// ----------------------------------------------------------------------------
`default_nettype none

module hhd_framer
  import hhd_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output logic            emit,
  output result_t         result
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_PACKET_BYTES);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic             kind_is_event, kind_is_event_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       length_low, length_low_next;
  logic [CNT_W-1:0] packet_total, packet_total_next;
  logic             was_capped, was_capped_next;

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] hdr_len;
  logic [CNT_W-1:0] len_val;
  logic [CNT_W-1:0] sum;
  logic [CNT_W-1:0] cap_eff;
  logic             set_len;
  logic             over;
  logic [CNT_W-1:0] total_eff;
  logic             capped_eff;

  always_comb begin
    cnt_inc = byte_count + CNT_W'(1);
    hdr_len = kind_is_event ? EVT_HDR_BYTES : ACL_HDR_BYTES;
    // event length is byte 2; ACL length completes at byte 4 (little-endian)
    set_len = kind_is_event ? (byte_count == CNT_W'(2)) : (byte_count == CNT_W'(4));
    len_val = kind_is_event ? CNT_W'(rx_byte) : CNT_W'({rx_byte, length_low});
    sum     = hdr_len + len_val;
    cap_eff = (CAP < hdr_len) ? hdr_len : CAP;
    over    = sum > cap_eff;
    if (phase == PH_HEADER && set_len) begin
      total_eff  = over ? cap_eff : sum;
      capped_eff = over;
    end else begin
      total_eff  = packet_total;
      capped_eff = was_capped;
    end
  end

  always_comb begin
    phase_next         = phase;
    kind_is_event_next = kind_is_event;
    byte_count_next    = byte_count;
    length_low_next    = length_low;
    packet_total_next  = packet_total;
    was_capped_next    = was_capped;
    emit               = 1'b0;
    result.data_byte   = rx_byte;
    result.is_event    = kind_is_event;
    result.first_byte  = 1'b0;
    result.last_byte   = 1'b0;
    result.truncated   = 1'b0;

    if (accept) begin
      unique case (phase)
        PH_HEADER, PH_PAYLOAD: begin
          byte_count_next   = cnt_inc;
          packet_total_next = total_eff;
          was_capped_next   = capped_eff;
          emit              = 1'b1;
          if (phase == PH_HEADER && !kind_is_event && byte_count == CNT_W'(3)) begin
            length_low_next = rx_byte;
          end
          if (phase == PH_HEADER && cnt_inc < hdr_len) begin
            // still inside the header
          end else if (cnt_inc >= total_eff) begin
            phase_next       = PH_HUNT;
            result.last_byte = 1'b1;
            result.truncated = capped_eff;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        default: begin
          // hunting; the unused code also hunts
          if (rx_byte == TYPE_ACL || rx_byte == TYPE_EVT) begin
            kind_is_event_next = (rx_byte == TYPE_EVT);
            byte_count_next    = CNT_W'(1);
            length_low_next    = 8'd0;
            packet_total_next  = '0;
            was_capped_next    = 1'b0;
            phase_next         = PH_HEADER;
            emit               = 1'b1;
            result.is_event    = (rx_byte == TYPE_EVT);
            result.first_byte  = 1'b1;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      kind_is_event <= 1'b0;
      byte_count    <= '0;
      length_low    <= 8'd0;
      packet_total  <= '0;
      was_capped    <= 1'b0;
    end else begin
      phase         <= phase_next;
      kind_is_event <= kind_is_event_next;
      byte_count    <= byte_count_next;
      length_low    <= length_low_next;
      packet_total  <= packet_total_next;
      was_capped    <= was_capped_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hhd_out_reg.sv
// ----------------------------------------------------------------------------
// hhd_out_reg
// Result register: holds one framed byte until downstream takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hhd_out_reg
  import hhd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result,
  output logic         can_load,
  hhd_pkt_if.source    pkt
);

  logic    valid;
  result_t held;

  // free when empty or when the held byte leaves this cycle
  assign can_load = !valid || pkt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (pkt.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign pkt.valid      = valid;
  assign pkt.data_byte  = held.data_byte;
  assign pkt.is_event   = held.is_event;
  assign pkt.first_byte = held.first_byte;
  assign pkt.last_byte  = held.last_byte;
  assign pkt.truncated  = held.truncated;

endmodule

`default_nettype wire

FILE: sv/hci_h4_packet_deframer.sv
// ----------------------------------------------------------------------------
// hci_h4_packet_deframer
// Frames HCI H4 ACL and event packets out of a UART byte stream.
// ----------------------------------------------------------------------------
//   port  dir  carries
//   rx    in   rx_byte: one UART byte per request
//   pkt   out  data_byte, is_event, first_byte, last_byte, truncated
//
// One byte per cycle unless pkt stalls; a packet byte appears on pkt the
// cycle after it is taken, bytes dropped while hunting produce nothing.
// The single result register decides the rate: rx.ready is high whenever it
// is empty or being drained, so a stalled pkt stalls rx after one byte.
// Reset is synchronous; the deframer comes out of reset hunting for a type.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_h4_packet_deframer
  import hhd_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  hhd_byte_if.sink  rx,
  hhd_pkt_if.source pkt
);

  logic    accept;
  logic    emit;
  logic    can_load;
  result_t result;

  assign rx.ready = can_load;
  assign accept   = rx.valid && can_load;

  hhd_framer #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .emit    (emit),
    .result  (result)
  );

  hhd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (emit),
    .result   (result),
    .can_load (can_load),
    .pkt      (pkt)
  );

endmodule

`default_nettype wire

FILE: tb/hhd_deframer_checker.sv
// ----------------------------------------------------------------------------
// hhd_deframer_checker
// Watches both channels of the deframer, frames the accepted UART bytes on
// its own and compares every delivered packet byte with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module hhd_deframer_checker
  import hhd_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  hhd_byte_if       rx,
  hhd_pkt_if        pkt,
  output int        mismatches,
  output int        outstanding,
  output int        checked,
  output int        packets,
  output int        capped_packets
);

  typedef enum logic [1:0] {
    FRAME_HUNT,
    FRAME_HEADER,
    FRAME_PAYLOAD
  } frame_phase_e;

  frame_phase_e     phase;
  logic             kind_evt;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] total;
  logic [7:0]       len_lo;
  logic             capped;

  result_t expected_bytes[$];

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  // Packet length from the header, limited to the size cap (never below the header).
  function automatic void cap_total(input logic [CNT_W-1:0] hdr, input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] sum;
    limit = CNT_W'(MAX_PACKET_BYTES);
    if (limit < hdr) limit = hdr;
    sum = hdr + len;
    capped = (sum > limit);
    total = capped ? limit : sum;
  endfunction

  // Advances the framing state by one byte; returns 1 if the byte is passed on.
  function automatic bit frame_byte(input logic [7:0] b, output result_t r);
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] hdr;
    r = '0;
    if (phase == FRAME_HUNT) begin
      if (b != TYPE_ACL && b != TYPE_EVT) return 1'b0;
      kind_evt = (b == TYPE_EVT);
      count = CNT_W'(1);
      len_lo = '0;
      total = '0;
      capped = 1'b0;
      phase = FRAME_HEADER;
      r.data_byte = b;
      r.is_event = kind_evt;
      r.first_byte = 1'b1;
      return 1'b1;
    end
    idx = count;
    count = count + CNT_W'(1);
    r.data_byte = b;
    r.is_event = kind_evt;
    if (phase == FRAME_HEADER) begin
      hdr = kind_evt ? EVT_HDR_BYTES : ACL_HDR_BYTES;
      if (kind_evt && idx == CNT_W'(2)) cap_total(hdr, CNT_W'(b));
      else if (!kind_evt && idx == CNT_W'(3)) len_lo = b;
      else if (!kind_evt && idx == CNT_W'(4)) cap_total(hdr, CNT_W'({b, len_lo}));
      if (count < hdr) return 1'b1;
      phase = FRAME_PAYLOAD;
    end
    if (count >= total) begin
      phase = FRAME_HUNT;
      r.last_byte = 1'b1;
      r.truncated = capped;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t predicted;
    if (rst) begin
      phase = FRAME_HUNT;
      kind_evt = 1'b0;
      count = '0;
      total = '0;
      len_lo = '0;
      capped = 1'b0;
      expected_bytes.delete();
    end else begin
      // the result leaving now belongs to an earlier request, so check it first
      if (pkt.valid && pkt.ready) begin
        got = {pkt.data_byte, pkt.is_event, pkt.first_byte, pkt.last_byte, pkt.truncated};
        checked++;
        if (expected_bytes.size() == 0) begin
          report($sformatf("byte %0d: 0x%02h delivered with nothing due", checked,
                           got.data_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (got.data_byte !== want.data_byte)
            report($sformatf("byte %0d: data 0x%02h, want 0x%02h", checked,
                             got.data_byte, want.data_byte));
          if (got.is_event !== want.is_event)
            report($sformatf("byte %0d: is_event %b, want %b", checked,
                             got.is_event, want.is_event));
          if (got.first_byte !== want.first_byte)
            report($sformatf("byte %0d: first_byte %b, want %b", checked,
                             got.first_byte, want.first_byte));
          if (got.last_byte !== want.last_byte)
            report($sformatf("byte %0d: last_byte %b, want %b", checked,
                             got.last_byte, want.last_byte));
          if (got.truncated !== want.truncated)
            report($sformatf("byte %0d: truncated %b, want %b", checked,
                             got.truncated, want.truncated));
          if (want.last_byte) packets++;
          if (want.truncated) capped_packets++;
        end
      end
      if (rx.valid && rx.ready) begin
        if (frame_byte(rx.rx_byte, predicted)) expected_bytes.push_back(predicted);
      end
    end
    outstanding <= expected_bytes.size();
  end

endmodule

`default_nettype wire

FILE: tb/hci_h4_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// hci_h4_packet_deframer_test
// Drives UART bytes into the deframer: a short opening of edge cases, one
// packet over the size cap, then random ACL and event packets mixed with
// noise and cut-short packets, under random stalls on both sides and one
// long output hold-off. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_h4_packet_deframer_test;
  import hhd_pkg::*;

  localparam int MAX_BYTES = MAX_PACKET_BYTES_DEF;
  // random part only; the opening and the capped packet add about 1050 bytes
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  logic calm;
  logic hold_go;
  int   framed_items;

  int mismatches;
  int outstanding;
  int checked;
  int packets;
  int capped_packets;

  hhd_byte_if rx_ch();
  hhd_pkt_if  pkt_ch();

  hci_h4_packet_deframer #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .pkt(pkt_ch)
  );

  hhd_deframer_checker #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx_ch),
    .pkt           (pkt_ch),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked       (checked),
    .packets       (packets),
    .capped_packets(capped_packets)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: random back-pressure, a calm window, and one long hold-off.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    pkt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_ch.ready <= 1'b0;
      end else if (calm) begin
        pkt_ch.ready <= 1'b1;
      end else begin
        pkt_ch.ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  // valid stays high from one request to the next unless an idle cycle falls in between
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 22) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  // Header with random handle or event code, then at most cut payload bytes.
  task automatic send_packet(input bit evt, input int len, input int cut);
    int         body;
    logic [15:0] len16;
    len16 = len[15:0];
    body = (cut < len) ? cut : len;
    if (body > MAX_BYTES) body = MAX_BYTES;
    if (evt) begin
      send_byte(TYPE_EVT);
      send_byte(8'($urandom_range(255)));
      send_byte(len16[7:0]);
      framed_items += 3;
    end else begin
      send_byte(TYPE_ACL);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
      send_byte(len16[7:0]);
      send_byte(len16[15:8]);
      framed_items += 5;
    end
    repeat (body) send_byte(8'($urandom_range(255)));
    framed_items += body;
  endtask

  // Mostly short packets; a few long events and a few longer ACL payloads.
  function automatic int pick_len(input bit evt);
    int r;
    r = $urandom_range(99);
    if (evt) begin
      if (r < 3) return 255;
      if (r < 10) return $urandom_range(254, 60);
      if (r < 30) return 0;
      return $urandom_range(12);
    end
    if (r < 8) return $urandom_range(300, 13);
    if (r < 25) return 0;
    return $urandom_range(12);
  endfunction

  initial begin
    logic [7:0] opening[$];
    int         pick;
    int         len;
    int         drain;
    bit         calm_on;
    bit         calm_off;
    bit         hold_sent;
    opening = '{8'h00, 8'hFF, 8'h03, 8'h01,
                TYPE_EVT, 8'h3E, 8'h00,
                TYPE_ACL, 8'hFF, 8'hEF, 8'h00, 8'h00,
                TYPE_EVT, 8'h0E, 8'h02, 8'h00, 8'hFF,
                TYPE_ACL, 8'h01, 8'h00, 8'h03, 8'h00, 8'hAA, 8'h55, 8'h80};
    calm_on = 1'b0;
    calm_off = 1'b0;
    hold_sent = 1'b0;
    framed_items = 0;
    rst <= 1'b1;
    calm <= 1'b0;
    hold_go <= 1'b0;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // stray bytes while hunting, zero lengths, short payloads
    foreach (opening[i]) send_byte(opening[i]);
    // largest declared ACL length: cut at the cap, the tail goes back to hunting
    send_packet(1'b0, 16'hFFFF, MAX_BYTES - 5);
    send_byte(8'h7F);
    send_byte(TYPE_EVT);
    send_byte(8'h0F);
    send_byte(8'h00);

    framed_items = 0;
    while (framed_items < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        len = pick_len(pick[0]);
        // a cut-short packet leaves the following bytes inside its payload
        send_packet(pick[0], len, (pick < 16) ? $urandom_range(len) : len);
      end
      if (!calm_on && framed_items >= 150) begin
        calm_on = 1'b1;
        calm <= 1'b1;
      end else if (calm_on && !calm_off && framed_items >= 300) begin
        calm_off = 1'b1;
        calm <= 1'b0;
      end else if (calm_off && !hold_sent && framed_items >= 400) begin
        hold_sent = 1'b1;
        hold_go <= 1'b1;
      end
    end
    rx_ch.valid <= 1'b0;

    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while ((outstanding != 0 || drain < 2) && drain < 20000);
    repeat (8) @(posedge clk);

    $display("covered %0d packets (%0d cut at the %0d-byte cap), %0d bytes checked",
             packets, capped_packets, MAX_BYTES, checked);
    if (outstanding != 0) $display("%0d predicted bytes never delivered", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
